>>> design/dhc_pkg.sv
package dhc_pkg;

    localparam int unsigned HUE_SPAN   = 240;
    localparam int unsigned SECTOR_DEG = 60;
    localparam int unsigned Q8_ONE     = 256;
    localparam int unsigned X_ONE      = Q8_ONE * SECTOR_DEG;
    localparam int unsigned P_FULL     = 65536 * 60;

    localparam int unsigned QUO_W      = 8;
    localparam int unsigned DIV_STEP   = 2;
    localparam int unsigned DIV_STAGES = QUO_W / DIV_STEP;

    localparam logic [1:0] REG_MAX_DISP = 2'd0;
    localparam logic [1:0] REG_SAT      = 2'd1;
    localparam logic [1:0] REG_BRIGHT   = 2'd2;

    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] num;
        logic [7:0] quo;
        logic [7:0] dvs;
        logic       blank;
    } t_div_word;

    // restoring division, DIV_STEP quotient bits; rem stays below dvs
    function automatic t_div_word div_step(t_div_word w);
        t_div_word  o;
        logic [8:0] tr;
        o = w;
        for (int i = 0; i < DIV_STEP; i++) begin
            tr    = {o.rem, o.num[7]};
            o.num = {o.num[6:0], 1'b0};
            if (tr >= {1'b0, o.dvs}) begin
                tr    = tr - {1'b0, o.dvs};
                o.quo = {o.quo[6:0], 1'b1};
            end else begin
                o.quo = {o.quo[6:0], 1'b0};
            end
            o.rem = tr[7:0];
        end
        return o;
    endfunction

    // X_ONE - k*s, two's complement, range about -15300..15360
    function automatic logic signed [16:0] x_term(logic [5:0] k, logic [8:0] s);
        logic [14:0] ks;
        logic [16:0] d;
        ks = 15'(k) * 15'(s);
        d  = 17'(X_ONE) - 17'(ks);
        return $signed(d);
    endfunction

    // channel = P / (256*15360) clamped, scaled by 255: floor(P*17 / 2^18)
    function automatic logic [7:0] to_byte(logic signed [26:0] p);
        logic [25:0] m17;
        logic [7:0]  b;
        m17 = {p[21:0], 4'b0000} + 26'(p[21:0]);
        if (p[26] || (p == 27'sd0)) begin
            b = 8'd0;
        end else if (p >= 27'(P_FULL)) begin
            b = 8'd255;
        end else begin
            b = m17[25:18];
        end
        return b;
    endfunction

endpackage

>>> design/dhc_div.sv
module dhc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  dhc_pkg::t_div_word  i_word,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_quo,
    output logic                o_blank
);

    logic                           r_vld [dhc_pkg::DIV_STAGES];
    dhc_pkg::t_div_word             r_stg [dhc_pkg::DIV_STAGES];
    logic [dhc_pkg::DIV_STAGES:0]   rdy;

    assign rdy[dhc_pkg::DIV_STAGES] = !i_stall;

    for (genvar k = 0; k < dhc_pkg::DIV_STAGES; k++) begin : g_stg
        dhc_pkg::t_div_word w_in;
        logic               v_in;

        if (k == 0) begin : g_first
            assign w_in = i_word;
            assign v_in = i_valid;
        end else begin : g_next
            assign w_in = r_stg[k-1];
            assign v_in = r_vld[k-1];
        end

        assign rdy[k] = !r_vld[k] || rdy[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_vld[k] <= v_in;
            end
            if (rdy[k]) begin
                r_stg[k] <= dhc_pkg::div_step(w_in);
            end
        end
    end

    assign o_stall = !rdy[0];
    assign o_valid = r_vld[dhc_pkg::DIV_STAGES-1];
    assign o_quo   = r_stg[dhc_pkg::DIV_STAGES-1].quo;
    assign o_blank = r_stg[dhc_pkg::DIV_STAGES-1].blank;

endmodule

>>> design/disparity_hsv_colorizer.sv
// Maps one 8-bit disparity word to one blue/green/red word along the HSV hue
// wheel: max_disparity is hue 0 (red), zero disparity is hue 240 (blue);
// disparities above the maximum saturate to it, and a maximum of zero gives
// black. One word is taken every clock while o_stall is low. Each word passes
// through an input register, a 4-stage restoring divider (2 quotient bits per
// stage) for the hue division by max_disparity, sextant split, p/q/t terms,
// value multiply, and the output register. A stall on the output backs up
// through the stages only where no bubble can absorb it.
// Write the registers only while the pipeline is empty.
module disparity_hsv_colorizer (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_disparity,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_green,
    output logic [7:0]  o_red
);

    logic [7:0] r_max_disp;
    logic [8:0] r_sat;
    logic [8:0] r_bright;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_disp <= 8'd0;
            r_sat      <= 9'(dhc_pkg::Q8_ONE);
            r_bright   <= 9'(dhc_pkg::Q8_ONE);
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                dhc_pkg::REG_MAX_DISP: r_max_disp <= pwdata[7:0];
                dhc_pkg::REG_SAT:      r_sat      <= pwdata[8:0];
                dhc_pkg::REG_BRIGHT:   r_bright   <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            dhc_pkg::REG_MAX_DISP: prdata = {24'd0, r_max_disp};
            dhc_pkg::REG_SAT:      prdata = {23'd0, r_sat};
            dhc_pkg::REG_BRIGHT:   prdata = {23'd0, r_bright};
            default:               prdata = 32'd0;
        endcase
    end

    // ready chain, output side first
    logic rdy_e, rdy_d, rdy_c, rdy_b, rdy_a;
    logic div_stall, div_vld, div_blank;
    logic [7:0] div_quo;

    // stage A: clamp, difference, numerator
    logic               r_a_vld;
    dhc_pkg::t_div_word r_a_word;
    dhc_pkg::t_div_word n_a_word;
    logic [7:0]         dcl;
    logic [7:0]         diff;
    logic [15:0]        numer;

    always_comb begin
        dcl            = (i_disparity > r_max_disp) ? r_max_disp : i_disparity;
        diff           = r_max_disp - dcl;
        numer          = 16'(diff) * 16'(dhc_pkg::HUE_SPAN);
        n_a_word.rem   = numer[15:8];
        n_a_word.num   = numer[7:0];
        n_a_word.quo   = 8'd0;
        n_a_word.dvs   = r_max_disp;
        n_a_word.blank = (r_max_disp == 8'd0);
    end

    assign rdy_a   = !r_a_vld || !div_stall;
    assign o_stall = !rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (rdy_a) begin
            r_a_vld <= i_valid;
        end
        if (rdy_a) begin
            r_a_word <= n_a_word;
        end
    end

    dhc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_vld),
        .o_stall (div_stall),
        .i_word  (r_a_word),
        .o_valid (div_vld),
        .i_stall (!rdy_b),
        .o_quo   (div_quo),
        .o_blank (div_blank)
    );

    // stage B: sextant and remainder within it
    logic       r_b_vld, r_b_blank;
    logic [2:0] r_b_sect;
    logic [5:0] r_b_frac;
    logic [2:0] n_b_sect;
    logic [7:0] n_b_frac;

    always_comb begin
        if (div_quo >= 8'd240) begin
            n_b_sect = 3'd4;
        end else if (div_quo >= 8'd180) begin
            n_b_sect = 3'd3;
        end else if (div_quo >= 8'd120) begin
            n_b_sect = 3'd2;
        end else if (div_quo >= 8'd60) begin
            n_b_sect = 3'd1;
        end else begin
            n_b_sect = 3'd0;
        end
        n_b_frac = div_quo - 8'(n_b_sect) * 8'(dhc_pkg::SECTOR_DEG);
    end

    assign rdy_b = !r_b_vld || rdy_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (rdy_b) begin
            r_b_vld <= div_vld;
        end
        if (rdy_b) begin
            r_b_blank <= div_blank;
            r_b_sect  <= n_b_sect;
            r_b_frac  <= n_b_frac[5:0];
        end
    end

    // stage C: p, q, t numerators in units of 1/15360
    logic                r_c_vld, r_c_blank;
    logic [2:0]          r_c_sect;
    logic signed [16:0]  r_c_xp, r_c_xq, r_c_xt;

    assign rdy_c = !r_c_vld || rdy_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (rdy_c) begin
            r_c_vld <= r_b_vld;
        end
        if (rdy_c) begin
            r_c_blank <= r_b_blank;
            r_c_sect  <= r_b_sect;
            r_c_xp    <= dhc_pkg::x_term(6'(dhc_pkg::SECTOR_DEG), r_sat);
            r_c_xq    <= dhc_pkg::x_term(r_b_frac, r_sat);
            r_c_xt    <= dhc_pkg::x_term(6'(dhc_pkg::SECTOR_DEG) - r_b_frac, r_sat);
        end
    end

    // stage D: channel select, times value
    logic                r_d_vld, r_d_blank;
    logic signed [26:0]  r_d_pb, r_d_pg, r_d_pr;
    logic signed [16:0]  xv;
    logic signed [16:0]  xb, xg, xr;
    logic signed [9:0]   vs;

    assign xv = $signed(17'(dhc_pkg::X_ONE));
    assign vs = $signed({1'b0, r_bright});

    always_comb begin
        case (r_c_sect)
            3'd0: begin xb = r_c_xp; xg = r_c_xt; xr = xv;     end
            3'd1: begin xb = r_c_xp; xg = xv;     xr = r_c_xq; end
            3'd2: begin xb = r_c_xt; xg = xv;     xr = r_c_xp; end
            3'd3: begin xb = xv;     xg = r_c_xq; xr = r_c_xp; end
            3'd4: begin xb = xv;     xg = r_c_xp; xr = r_c_xt; end
            default: begin xb = r_c_xq; xg = r_c_xp; xr = xv; end
        endcase
    end

    assign rdy_d = !r_d_vld || rdy_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (rdy_d) begin
            r_d_vld <= r_c_vld;
        end
        if (rdy_d) begin
            r_d_blank <= r_c_blank;
            r_d_pb    <= 27'(vs * xb);
            r_d_pg    <= 27'(vs * xg);
            r_d_pr    <= 27'(vs * xr);
        end
    end

    // stage E: clamp and scale, output register
    logic       r_o_vld;
    logic [7:0] r_o_blue, r_o_green, r_o_red;

    assign rdy_e = !r_o_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (rdy_e) begin
            r_o_vld <= r_d_vld;
        end
        if (rdy_e) begin
            r_o_blue  <= r_d_blank ? 8'd0 : dhc_pkg::to_byte(r_d_pb);
            r_o_green <= r_d_blank ? 8'd0 : dhc_pkg::to_byte(r_d_pg);
            r_o_red   <= r_d_blank ? 8'd0 : dhc_pkg::to_byte(r_d_pr);
        end
    end

    assign o_valid = r_o_vld;
    assign o_blue  = r_o_blue;
    assign o_green = r_o_green;
    assign o_red   = r_o_red;

endmodule

>>> sim/disparity_hsv_colorizer_tb.sv
module disparity_hsv_colorizer_tb;

    localparam logic [1:0]  REG_NONE   = 2'd3;
    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned HOLD_LEN   = 80;
    localparam int unsigned DRAIN_WAIT = 12;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel_bgr;

    class colormap_scoreboard;
        logic [7:0]  max_disp;
        logic [8:0]  sat;
        logic [8:0]  bright;
        t_pixel_bgr  expected_pixels[$];
        int unsigned errors;

        function new();
            max_disp = 8'd0;
            sat      = 9'd256;
            bright   = 9'd256;
            errors   = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                dhc_pkg::REG_MAX_DISP: max_disp = val[7:0];
                dhc_pkg::REG_SAT:      sat      = val[8:0];
                dhc_pkg::REG_BRIGHT:   bright   = val[8:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] to_channel(longint num);
            longint full;
            full = longint'(65536) * 60;
            if (num <= 0)
                return 8'd0;
            if (num >= full)
                return 8'd255;
            return 8'((num * 255) / full);
        endfunction

        function t_pixel_bgr colorize(logic [7:0] disp);
            t_pixel_bgr  px;
            int unsigned d, m, hue, sextant;
            longint      k_one, k_sec, f, s, v;
            logic [7:0]  cv, cp, cq, ct;
            m = max_disp;
            d = disp;
            if (m == 0) begin
                px = '0;
                return px;
            end
            if (d > m)
                d = m;
            hue     = ((m - d) * dhc_pkg::HUE_SPAN) / m;
            sextant = hue / dhc_pkg::SECTOR_DEG;
            f       = hue % dhc_pkg::SECTOR_DEG;
            k_one   = dhc_pkg::Q8_ONE;
            k_sec   = dhc_pkg::SECTOR_DEG;
            s       = sat;
            v       = bright;
            cv = to_channel(v * k_one * k_sec);
            cp = to_channel(v * (k_one - s) * k_sec);
            cq = to_channel(v * (k_one * k_sec - f * s));
            ct = to_channel(v * (k_one * k_sec - (k_sec - f) * s));
            case (sextant)
                0:       px = {cp, ct, cv};
                1:       px = {cp, cv, cq};
                2:       px = {ct, cv, cp};
                3:       px = {cv, cq, cp};
                4:       px = {cv, cp, ct};
                default: px = {cq, cp, cv};
            endcase
            return px;
        endfunction

        function void note_pixel(logic [7:0] disp);
            expected_pixels.push_back(colorize(disp));
        endfunction

        function void check_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
            t_pixel_bgr want;
            if (expected_pixels.size() == 0) begin
                $error("unexpected word: blue %0d green %0d red %0d", b, g, r);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            if (b !== want.blue) begin
                $error("blue: expected %0d, got %0d", want.blue, b);
                errors++;
            end
            if (g !== want.green) begin
                $error("green: expected %0d, got %0d", want.green, g);
                errors++;
            end
            if (r !== want.red) begin
                $error("red: expected %0d, got %0d", want.red, r);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_disparity;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_blue;
    logic [7:0]  o_green;
    logic [7:0]  o_red;

    colormap_scoreboard sb;
    bit                 hold_off_req = 1'b0;
    int unsigned        idle_cycles  = 0;
    int unsigned        burst_left   = 0;

    disparity_hsv_colorizer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_disparity (i_disparity),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_blue      (o_blue),
        .o_green     (o_green),
        .o_red       (o_red)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0)
            sb.check_pixel(o_blue, o_green, o_red);
    end

    always @(posedge i_clk) begin
        if ((i_valid === 1'b1 && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: stall pattern in runs of random mode, plus one long hold-off
    initial begin
        int unsigned run_left;
        int unsigned mode;
        int unsigned cyc;
        run_left = 0;
        mode     = 0;
        cyc      = 0;
        i_stall  = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_LEN) @(negedge i_clk);
            end else begin
                if (run_left == 0) begin
                    run_left = $urandom_range(20, 200);
                    mode     = $urandom_range(0, 3);
                end
                run_left--;
                case (mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 99) < 30);
                    2:       i_stall <= ($urandom_range(0, 99) < 70);
                    default: i_stall <= (cyc % 5 == 0);
                endcase
            end
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] wdata;
        mask  = (idx == dhc_pkg::REG_MAX_DISP) ? 32'h0FF : 32'h1FF;
        wdata = ($urandom() & ~mask) | (value & mask);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.write_reg(idx, wdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic configure(input int unsigned m, input int unsigned s, input int unsigned v);
        drain();
        apb_write(dhc_pkg::REG_MAX_DISP, m);
        apb_write(dhc_pkg::REG_SAT, s);
        apb_write(dhc_pkg::REG_BRIGHT, v);
    endtask

    task automatic send_pixel(input logic [7:0] d);
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_disparity <= d;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_pixel(d);
    endtask

    task automatic stop_sending(input int unsigned cycles);
        @(negedge i_clk);
        i_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic send_directed(input int unsigned vals[$]);
        foreach (vals[i])
            send_pixel(8'(vals[i]));
        stop_sending(1);
    endtask

    function automatic logic [7:0] pick_disparity(logic [7:0] m);
        case ($urandom_range(0, 9))
            0:       return m;
            1:       return (m == 8'd255) ? m : m + 8'd1;
            2:       return (m == 8'd0) ? m : m - 8'd1;
            3:       return 8'd255;
            4:       return 8'd0;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int unsigned pick_q8();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 256;
            2:       return 511;
            3:       return $urandom_range(230, 280);
            default: return $urandom_range(0, 511);
        endcase
    endfunction

    function automatic int unsigned pick_max();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 1;
            2:       return 255;
            default: return $urandom_range(1, 255);
        endcase
    endfunction

    task automatic send_stream(input int unsigned n, input int unsigned gap_max);
        for (int unsigned i = 0; i < n; i++) begin
            if (gap_max > 0 && burst_left == 0) begin
                stop_sending($urandom_range(1, gap_max));
                burst_left = $urandom_range(1, 50);
            end
            send_pixel(pick_disparity(sb.max_disp));
            if (burst_left > 0)
                burst_left--;
        end
        stop_sending(1);
    endtask

    initial begin
        int unsigned gap_max;
        sb          = new();
        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        i_valid     = 1'b0;
        i_disparity = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero maximum gives black; unmapped index is ignored
        apb_write(REG_NONE, $urandom());
        send_directed('{0, 255, 170});

        configure(255, 256, 256);
        send_directed('{0, 1, 63, 64, 127, 128, 191, 192, 254, 255});

        // disparity above the maximum saturates to hue zero
        configure(100, 256, 256);
        send_directed('{0, 50, 99, 100, 101, 255});

        // saturation and brightness above one
        configure(1, 511, 511);
        send_directed('{0, 1, 255});

        configure(200, 0, 0);
        send_directed('{0, 100});

        for (int ph = 0; ph < 11; ph++) begin
            configure(pick_max(), pick_q8(), pick_q8());
            if (ph == 3) begin
                hold_off_req = 1'b1;
                send_stream(150, 0);
            end else begin
                case ($urandom_range(0, 2))
                    0:       gap_max = 0;
                    1:       gap_max = 3;
                    default: gap_max = 10;
                endcase
                send_stream(105, gap_max);
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
